// ===== rtl/bsim_pkg.sv =====
// ----------------------------------------------------------------------------
// bsim_pkg: shared types and codes of the bank switch / IRQ counter mapper
// Request and result payload structs, command codes, address page codes
// and bank select codes.
// ----------------------------------------------------------------------------
package bsim_pkg;

    localparam int unsigned CNT_W  = 16;
    localparam int unsigned BANK_W = 4;
    localparam int unsigned NIB_W  = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Address pages, decoded from cpu_address[15:12]
    localparam logic [3:0] PAGE_CNT_NIB0 = 4'h8;
    localparam logic [3:0] PAGE_CNT_NIB1 = 4'h9;
    localparam logic [3:0] PAGE_CNT_NIB2 = 4'hA;
    localparam logic [3:0] PAGE_CNT_NIB3 = 4'hB;
    localparam logic [3:0] PAGE_IRQ_CTRL = 4'hC;
    localparam logic [3:0] PAGE_SELECT   = 4'hE;
    localparam logic [3:0] PAGE_BANK     = 4'hF;

    // Bank select codes, from select_byte[3:0]
    localparam logic [3:0] SEL_PRG0 = 4'd1;
    localparam logic [3:0] SEL_PRG1 = 4'd2;
    localparam logic [3:0] SEL_PRG2 = 4'd3;
    localparam logic [3:0] SEL_WRAM = 4'd4;

    typedef struct packed {
        logic        command;
        logic [15:0] cpu_address;
        logic [7:0]  write_byte;
    } req_item_t;

    typedef struct packed {
        logic [BANK_W-1:0] prg_bank_slot0;
        logic [BANK_W-1:0] prg_bank_slot1;
        logic [BANK_W-1:0] prg_bank_slot2;
        logic [BANK_W-1:0] wram_bank;
        logic              irq_line;
        logic [CNT_W-1:0]  counter_value;
    } rsp_item_t;

endpackage

// ===== rtl/bsim_if.sv =====
// ----------------------------------------------------------------------------
// bsim_if: request and result channels of the mapper
// Valid/ready channels carrying the request fields and the result fields.
// ----------------------------------------------------------------------------
interface bsim_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] cpu_address;
    logic [7:0]  write_byte;

    modport source (output valid, output command, output cpu_address,
                    output write_byte, input ready);
    modport sink   (input valid, input command, input cpu_address,
                    input write_byte, output ready);
endinterface

interface bsim_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  prg_bank_slot0;
    logic [3:0]  prg_bank_slot1;
    logic [3:0]  prg_bank_slot2;
    logic [3:0]  wram_bank;
    logic        irq_line;
    logic [15:0] counter_value;

    modport source (output valid, output prg_bank_slot0, output prg_bank_slot1,
                    output prg_bank_slot2, output wram_bank, output irq_line,
                    output counter_value, input ready);
    modport sink   (input valid, input prg_bank_slot0, input prg_bank_slot1,
                    input prg_bank_slot2, input wram_bank, input irq_line,
                    input counter_value, output ready);
endinterface

// ===== rtl/bank_switch_irq_counter_mapper_top.sv =====
// ----------------------------------------------------------------------------
// bank_switch_irq_counter_mapper_top: bank switching mapper with cycle IRQ
// Takes CPU writes and CPU-cycle ticks, returns bank and IRQ state per request.
// ----------------------------------------------------------------------------
// Result path: an accepted request is held in the input register, then in
//   the result register; the state update between the two registers is a
//   single pass of nibble muxing and one 16-bit increment.
// Throughput: 1 request per cycle unless the result channel stalls.
// Reset: rst_n clears all mapper state, banks included, and empties both stages.
module bank_switch_irq_counter_mapper_top (
    input  logic              clk,
    input  logic              rst_n,
    bsim_req_if.sink          req,
    bsim_rsp_if.source        rsp
);

    // Input stage: holds one accepted request until it can be applied.
    bsim_pkg::req_item_t req_reg;
    logic                req_valid_reg;

    // Result stage: holds the state view after the last applied request.
    bsim_pkg::rsp_item_t rsp_reg;
    logic                rsp_valid_reg;

    bsim_pkg::rsp_item_t core_result;
    logic                advance;

    // Apply the held request when the result register is free or draining.
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    // Take a new request whenever the input stage empties this cycle.
    assign req.ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            req_valid_reg <= req.valid;
        end
    end

    // Payload: capture on acceptance only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg.command     <= req.command;
            req_reg.cpu_address <= req.cpu_address;
            req_reg.write_byte  <= req.write_byte;
        end
    end

    bsim_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (req_reg),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Load a fresh result on every applied request; hold it while stalled.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= core_result;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.prg_bank_slot0 = rsp_reg.prg_bank_slot0;
    assign rsp.prg_bank_slot1 = rsp_reg.prg_bank_slot1;
    assign rsp.prg_bank_slot2 = rsp_reg.prg_bank_slot2;
    assign rsp.wram_bank      = rsp_reg.wram_bank;
    assign rsp.irq_line       = rsp_reg.irq_line;
    assign rsp.counter_value  = rsp_reg.counter_value;

endmodule

// ===== rtl/bsim_core.sv =====
// ----------------------------------------------------------------------------
// bsim_core: mapper state and its update
// Holds counter, enable, pending IRQ, select and bank registers; computes
// the state after one request and presents it as the result.
// ----------------------------------------------------------------------------
module bsim_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  bsim_pkg::req_item_t  item,
    output bsim_pkg::rsp_item_t  result
);

    logic [bsim_pkg::CNT_W-1:0]  cnt_reg,   cnt_next;
    logic                        en_reg,    en_next;
    logic                        pend_reg,  pend_next;
    logic [7:0]                  sel_reg,   sel_next;
    logic [bsim_pkg::BANK_W-1:0] prg0_reg,  prg0_next;
    logic [bsim_pkg::BANK_W-1:0] prg1_reg,  prg1_next;
    logic [bsim_pkg::BANK_W-1:0] prg2_reg,  prg2_next;
    logic [bsim_pkg::BANK_W-1:0] wram_reg,  wram_next;

    logic [bsim_pkg::NIB_W-1:0]  nib;
    logic [3:0]                  page;

    assign nib  = item.write_byte[3:0];
    assign page = item.cpu_address[15:12];

    always_comb
    begin
        cnt_next  = cnt_reg;
        en_next   = en_reg;
        pend_next = pend_reg;
        sel_next  = sel_reg;
        prg0_next = prg0_reg;
        prg1_next = prg1_reg;
        prg2_next = prg2_reg;
        wram_next = wram_reg;
        if (item.command == bsim_pkg::CMD_TICK)
        begin
            if (en_reg)
            begin
                if (cnt_reg == bsim_pkg::CNT_MAX)
                begin
                    en_next   = 1'b0;
                    cnt_next  = '0;
                    pend_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 16'd1;
                end
            end
        end
        else
        begin
            case (page)
                bsim_pkg::PAGE_CNT_NIB0: cnt_next[3:0]   = nib;
                bsim_pkg::PAGE_CNT_NIB1: cnt_next[7:4]   = nib;
                bsim_pkg::PAGE_CNT_NIB2: cnt_next[11:8]  = nib;
                bsim_pkg::PAGE_CNT_NIB3: cnt_next[15:12] = nib;
                bsim_pkg::PAGE_IRQ_CTRL:
                begin
                    en_next   = (nib != '0);
                    pend_next = 1'b0;
                end
                bsim_pkg::PAGE_SELECT: sel_next = item.write_byte;
                bsim_pkg::PAGE_BANK:
                begin
                    case (sel_reg[3:0])
                        bsim_pkg::SEL_PRG0: prg0_next = nib;
                        bsim_pkg::SEL_PRG1: prg1_next = nib;
                        bsim_pkg::SEL_PRG2: prg2_next = nib;
                        bsim_pkg::SEL_WRAM: wram_next = nib;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            en_reg   <= 1'b0;
            pend_reg <= 1'b0;
            sel_reg  <= '0;
            prg0_reg <= '0;
            prg1_reg <= '0;
            prg2_reg <= '0;
            wram_reg <= '0;
        end
        else if (advance)
        begin
            cnt_reg  <= cnt_next;
            en_reg   <= en_next;
            pend_reg <= pend_next;
            sel_reg  <= sel_next;
            prg0_reg <= prg0_next;
            prg1_reg <= prg1_next;
            prg2_reg <= prg2_next;
            wram_reg <= wram_next;
        end
    end

    always_comb
    begin
        result.prg_bank_slot0 = prg0_next;
        result.prg_bank_slot1 = prg1_next;
        result.prg_bank_slot2 = prg2_next;
        result.wram_bank      = wram_next;
        result.irq_line       = pend_next;
        result.counter_value  = cnt_next;
    end

endmodule

// ===== rtl/bsim_checker.sv =====
// ----------------------------------------------------------------------------
// bsim_checker: port-level checks of the mapper
// Watches the result channel over time and flags illegal sequences.
// ----------------------------------------------------------------------------
module bsim_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [3:0]  prg_bank_slot0,
    input logic [3:0]  prg_bank_slot1,
    input logic [3:0]  prg_bank_slot2,
    input logic [3:0]  wram_bank,
    input logic        irq_line,
    input logic [15:0] counter_value
);

    // No result is shown in the cycle after reset is seen.
    a_no_rsp_in_reset: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("result valid during reset");

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(counter_value) && $stable(irq_line)))
        else $error("stalled result changed");

    // IRQ rises only on counter wrap, which leaves the counter at zero.
    a_irq_rise_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && !irq_line) ##1 (rsp_valid && irq_line)
            |-> (counter_value == 16'h0000))
        else $error("IRQ raised with nonzero counter");

    // One request changes at most one bank register.
    a_one_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready) ##1 rsp_valid |->
            ($countones({prg_bank_slot0 != $past(prg_bank_slot0),
                         prg_bank_slot1 != $past(prg_bank_slot1),
                         prg_bank_slot2 != $past(prg_bank_slot2),
                         wram_bank != $past(wram_bank)}) <= 1))
        else $error("more than one bank changed by one request");

endmodule

bind bank_switch_irq_counter_mapper_top bsim_checker u_bsim_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .prg_bank_slot0 (rsp.prg_bank_slot0),
    .prg_bank_slot1 (rsp.prg_bank_slot1),
    .prg_bank_slot2 (rsp.prg_bank_slot2),
    .wram_bank      (rsp.wram_bank),
    .irq_line       (rsp.irq_line),
    .counter_value  (rsp.counter_value)
);
